// File: design/ps2mg_pkg.sv
package ps2mg_pkg;

  localparam int TRAVEL_WIDTH = 18;
  localparam int TRAVEL_OUT_W = 18;
  localparam int LEN_W        = 16;

  // byte position within a packet
  localparam logic [1:0] IDX_HEAD   = 2'd0;
  localparam logic [1:0] IDX_MIDDLE = 2'd1;
  localparam logic [1:0] IDX_TAIL   = 2'd2;

  // head byte bit positions
  localparam int B_LEFT   = 0;
  localparam int B_RIGHT  = 1;
  localparam int B_MIDDLE = 2;
  localparam int B_SYNC   = 3;
  localparam int B_XSIGN  = 4;
  localparam int B_YSIGN  = 5;
  localparam int B_XOVF   = 6;
  localparam int B_YOVF   = 7;

  // phase codes as seen on the result port
  localparam logic [1:0] PHASE_CODE_IDLE = 2'd0;
  localparam logic [1:0] PHASE_CODE_DRAW = 2'd1;
  localparam logic [1:0] PHASE_CODE_DONE = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_DRAW = 3'b010,
    PH_DONE = 3'b100
  } phase_t;

  typedef struct packed {
    logic [7:0] head;
    logic [7:0] middle;
    logic [7:0] tail;
  } pkt_t;

endpackage

// File: design/ps2mg_framer.sv
module ps2mg_framer
  import ps2mg_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       pkt_valid,
  input  logic       pkt_ready,
  output pkt_t       pkt
);

  logic [1:0] byte_idx_r, byte_idx_nxt;
  logic [7:0] head_r, head_nxt;
  logic [7:0] mid_r, mid_nxt;
  logic       primed_r, primed_nxt;
  logic       pkt_valid_r, pkt_valid_nxt;
  pkt_t       pkt_r, pkt_nxt;
  logic       in_fire;
  logic       emit;

  assign in_ready = !pkt_valid_r || pkt_ready;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    byte_idx_nxt  = byte_idx_r;
    head_nxt      = head_r;
    mid_nxt       = mid_r;
    primed_nxt    = primed_r;
    emit          = 1'b0;
    pkt_nxt       = pkt_r;
    if (in_fire) begin
      if (byte_idx_r == IDX_MIDDLE) begin
        mid_nxt = in_rx_byte;
      end else if (byte_idx_r != IDX_TAIL) begin
        head_nxt = in_rx_byte;
      end
      if (!head_nxt[B_SYNC]) begin
        byte_idx_nxt = IDX_HEAD;
      end else if (byte_idx_r == IDX_MIDDLE) begin
        byte_idx_nxt = IDX_TAIL;
      end else if (byte_idx_r != IDX_TAIL) begin
        byte_idx_nxt = IDX_MIDDLE;
      end else begin
        byte_idx_nxt = IDX_HEAD;
        // first complete packet after reset is swallowed
        if (!primed_r) begin
          primed_nxt = 1'b1;
        end else begin
          emit = 1'b1;
        end
      end
    end
    if (emit) begin
      pkt_nxt.head   = head_nxt;
      pkt_nxt.middle = mid_nxt;
      pkt_nxt.tail   = in_rx_byte;
    end
    if (emit) begin
      pkt_valid_nxt = 1'b1;
    end else if (pkt_ready) begin
      pkt_valid_nxt = 1'b0;
    end else begin
      pkt_valid_nxt = pkt_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_idx_r  <= IDX_HEAD;
      head_r      <= '0;
      mid_r       <= '0;
      primed_r    <= 1'b0;
      pkt_valid_r <= 1'b0;
    end else begin
      byte_idx_r  <= byte_idx_nxt;
      head_r      <= head_nxt;
      mid_r       <= mid_nxt;
      primed_r    <= primed_nxt;
      pkt_valid_r <= pkt_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pkt_r <= pkt_nxt;
  end

  assign pkt_valid = pkt_valid_r;
  assign pkt       = pkt_r;

  a_idx_reachable: assert property (@(posedge clk) disable iff (!rst_n)
    byte_idx_r != 2'd3)
    else $error("framer byte index left the three-byte cycle");

  a_pkt_from_tail: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(pkt_valid_r) |-> ($past(byte_idx_r) == IDX_TAIL && $past(primed_r)))
    else $error("packet loaded without a primed tail byte");

endmodule

// File: design/ps2mg_gesture.sv
module ps2mg_gesture
  import ps2mg_pkg::*;
(
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           pkt_valid,
  output logic                           pkt_ready,
  input  pkt_t                           pkt,
  input  logic signed [LEN_W-1:0]        gesture_length,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_left_button,
  output logic                           out_middle_button,
  output logic                           out_right_button,
  output logic                           out_x_overflow,
  output logic                           out_y_overflow,
  output logic signed [8:0]              out_x_move,
  output logic signed [8:0]              out_y_move,
  output logic [1:0]                     out_gesture_phase_out,
  output logic signed [TRAVEL_OUT_W-1:0] out_travel_out
);

  localparam int TW = TRAVEL_WIDTH;

  phase_t                 phase_r, phase_nxt;
  logic signed [TW-1:0]   travel_r, travel_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   pkt_fire;
  logic                   held, xneg, yneg, len_pos, len_neg, dir_ok, add_en, reach;
  logic signed [8:0]      ym;
  logic signed [TW:0]     sum;
  logic signed [TW-1:0]   sum_sat, travel_upd, len_ext;
  logic [TW+TRAVEL_OUT_W-1:0] travel_wide;
  logic [1:0]             phase_code;

  logic                   left_r, middle_r, right_r, xovf_r, yovf_r;
  logic signed [8:0]      xm_r, ym_r;
  logic [1:0]             phase_out_r;
  logic signed [TRAVEL_OUT_W-1:0] travel_out_r;

  assign pkt_ready = !out_valid_r || out_ready;
  assign pkt_fire  = pkt_valid && pkt_ready;

  assign held    = pkt.head[B_RIGHT];
  assign xneg    = pkt.head[B_XSIGN];
  assign yneg    = pkt.head[B_YSIGN];
  assign len_neg = gesture_length[LEN_W-1];
  assign len_pos = !len_neg && (gesture_length != '0);
  assign dir_ok  = (len_pos && !xneg) || (len_neg && xneg);
  assign add_en  = dir_ok && ((len_neg && yneg) || (len_pos && !yneg));
  assign ym      = {yneg, pkt.tail};
  assign len_ext = {{(TW-LEN_W){gesture_length[LEN_W-1]}}, gesture_length};

  assign sum = {travel_r[TW-1], travel_r} + {{(TW-8){ym[8]}}, ym};

  always_comb begin
    if (sum[TW] != sum[TW-1]) begin
      sum_sat = sum[TW] ? {1'b1, {(TW-1){1'b0}}} : {1'b0, {(TW-1){1'b1}}};
    end else begin
      sum_sat = sum[TW-1:0];
    end
  end

  assign travel_upd = add_en ? sum_sat : travel_r;
  assign reach = dir_ok && ((len_pos && travel_upd >= len_ext) ||
                            (len_neg && travel_upd <= len_ext));

  always_comb begin
    phase_nxt  = phase_r;
    travel_nxt = travel_r;
    if (pkt_fire) begin
      travel_nxt = held ? travel_upd : '0;
      unique case (phase_r)
        PH_IDLE: begin
          if (held) phase_nxt = reach ? PH_DONE : PH_DRAW;
        end
        PH_DRAW: begin
          if (!held) phase_nxt = PH_IDLE;
          else if (reach) phase_nxt = PH_DONE;
        end
        PH_DONE: phase_nxt = PH_DONE;
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  always_comb begin
    unique case (phase_nxt)
      PH_IDLE: phase_code = PHASE_CODE_IDLE;
      PH_DRAW: phase_code = PHASE_CODE_DRAW;
      PH_DONE: phase_code = PHASE_CODE_DONE;
      default: phase_code = PHASE_CODE_IDLE;
    endcase
  end

  // sign-extend then keep the low bits, valid for any travel width
  assign travel_wide = {{TRAVEL_OUT_W{travel_nxt[TW-1]}}, travel_nxt};

  always_comb begin
    if (pkt_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      travel_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      travel_r    <= travel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pkt_fire) begin
      left_r       <= pkt.head[B_LEFT];
      middle_r     <= pkt.head[B_MIDDLE];
      right_r      <= pkt.head[B_RIGHT];
      xovf_r       <= pkt.head[B_XOVF];
      yovf_r       <= pkt.head[B_YOVF];
      xm_r         <= {xneg, pkt.middle};
      ym_r         <= ym;
      phase_out_r  <= phase_code;
      travel_out_r <= travel_wide[TRAVEL_OUT_W-1:0];
    end
  end

  assign out_valid             = out_valid_r;
  assign out_left_button       = left_r;
  assign out_middle_button     = middle_r;
  assign out_right_button      = right_r;
  assign out_x_overflow        = xovf_r;
  assign out_y_overflow        = yovf_r;
  assign out_x_move            = xm_r;
  assign out_y_move            = ym_r;
  assign out_gesture_phase_out = phase_out_r;
  assign out_travel_out        = travel_out_r;

  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DONE |=> phase_r == PH_DONE)
    else $error("completed gesture left the done phase");

  a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (pkt_fire && !held) |=> (travel_r == '0 && out_travel_out == '0))
    else $error("travel not cleared on right button release");

endmodule

// File: design/ps2_mouse_packet_gesture_top.sv
// The framing register loads a packet at the transfer of its third byte; the result is valid once
//   the gesture/result register loads it, when the gesture stage accepts the packet.
// Throughput: one byte per cycle while in_ready is high; each stage holds one item and advances when the next is free.
// Reset (rst_n low, synchronous) clears framing, the first-packet drop flag, the travel
//   accumulator and gesture_length to zero, and returns the gesture phase to idle.
module ps2_mouse_packet_gesture_top
  import ps2mg_pkg::*;
(
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic signed [LEN_W-1:0]        cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_rx_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_left_button,
  output logic                           out_middle_button,
  output logic                           out_right_button,
  output logic                           out_x_overflow,
  output logic                           out_y_overflow,
  output logic signed [8:0]              out_x_move,
  output logic signed [8:0]              out_y_move,
  output logic [1:0]                     out_gesture_phase_out,
  output logic signed [TRAVEL_OUT_W-1:0] out_travel_out
);

  logic signed [LEN_W-1:0] gesture_length_r;
  logic                    pkt_valid;
  logic                    pkt_ready;
  pkt_t                    pkt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gesture_length_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      gesture_length_r <= cfg_data;
    end
  end

  ps2mg_framer u_framer (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .pkt_valid  (pkt_valid),
    .pkt_ready  (pkt_ready),
    .pkt        (pkt)
  );

  ps2mg_gesture u_gesture (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .pkt_valid             (pkt_valid),
    .pkt_ready             (pkt_ready),
    .pkt                   (pkt),
    .gesture_length        (gesture_length_r),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_left_button       (out_left_button),
    .out_middle_button     (out_middle_button),
    .out_right_button      (out_right_button),
    .out_x_overflow        (out_x_overflow),
    .out_y_overflow        (out_y_overflow),
    .out_x_move            (out_x_move),
    .out_y_move            (out_y_move),
    .out_gesture_phase_out (out_gesture_phase_out),
    .out_travel_out        (out_travel_out)
  );

endmodule

// File: tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ps2mg_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int RANDOM_BYTES   = 120;
  localparam longint TRAVEL_MAX = (longint'(1) <<< (TRAVEL_WIDTH - 1)) - 1;
  localparam longint TRAVEL_MIN = -TRAVEL_MAX - 1;
  localparam logic signed [LEN_W-1:0] LEN_MAX = {1'b0, {(LEN_W-1){1'b1}}};
  localparam logic signed [LEN_W-1:0] LEN_MIN = {1'b1, {(LEN_W-1){1'b0}}};

  typedef struct packed {
    logic                    left_btn;
    logic                    middle_btn;
    logic                    right_btn;
    logic                    x_ovf;
    logic                    y_ovf;
    logic [8:0]              x_move;
    logic [8:0]              y_move;
    logic [1:0]              phase;
    logic [TRAVEL_OUT_W-1:0] travel;
  } mouse_report_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic signed [LEN_W-1:0]        cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [7:0]                     in_rx_byte = '0;
  logic                           out_valid;
  logic                           out_ready;
  logic                           out_left_button;
  logic                           out_middle_button;
  logic                           out_right_button;
  logic                           out_x_overflow;
  logic                           out_y_overflow;
  logic signed [8:0]              out_x_move;
  logic signed [8:0]              out_y_move;
  logic [1:0]                     out_gesture_phase_out;
  logic signed [TRAVEL_OUT_W-1:0] out_travel_out;

  // decoder state as predicted from accepted bytes
  logic signed [LEN_W-1:0] gest_length = '0;
  logic [1:0]              frame_idx = IDX_HEAD;
  logic [7:0]              frame_head = '0;
  logic [7:0]              frame_middle = '0;
  logic                    first_pkt_dropped = 1'b0;
  logic [1:0]              gest_phase = PHASE_CODE_IDLE;
  longint                  gest_travel = 0;

  mouse_report_t pending_reports[$];
  mouse_report_t due_report;
  int            failures = 0;
  bit            tight_input = 1'b0;

  ps2_mouse_packet_gesture_top DUT (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_data              (cfg_data),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_rx_byte            (in_rx_byte),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_left_button       (out_left_button),
    .out_middle_button     (out_middle_button),
    .out_right_button      (out_right_button),
    .out_x_overflow        (out_x_overflow),
    .out_y_overflow        (out_y_overflow),
    .out_x_move            (out_x_move),
    .out_y_move            (out_y_move),
    .out_gesture_phase_out (out_gesture_phase_out),
    .out_travel_out        (out_travel_out)
  );

  always #5 clk = ~clk;

  // Advance framing by one byte; returns 1 when a report is due.
  function automatic logic decode_byte(input logic [7:0] b, output mouse_report_t rep);
    logic [7:0] tail_b;
    logic       xneg;
    logic       yneg;
    longint     ym;
    longint     len;
    tail_b = '0;
    rep = '0;
    case (frame_idx)
      IDX_MIDDLE: frame_middle = b;
      IDX_TAIL:   tail_b = b;
      default:    frame_head = b;
    endcase
    if (!frame_head[B_SYNC]) begin
      frame_idx = IDX_HEAD;
      return 1'b0;
    end
    if (frame_idx != IDX_TAIL) begin
      frame_idx = (frame_idx == IDX_MIDDLE) ? IDX_TAIL : IDX_MIDDLE;
      return 1'b0;
    end
    frame_idx = IDX_HEAD;
    if (!first_pkt_dropped) begin
      first_pkt_dropped = 1'b1;
      return 1'b0;
    end
    xneg = frame_head[B_XSIGN];
    yneg = frame_head[B_YSIGN];
    ym = yneg ? longint'(tail_b) - 256 : longint'(tail_b);
    len = gest_length;
    if (!frame_head[B_RIGHT]) begin
      if (gest_phase == PHASE_CODE_DRAW) gest_phase = PHASE_CODE_IDLE;
      gest_travel = 0;
    end else begin
      if (gest_phase == PHASE_CODE_IDLE) gest_phase = PHASE_CODE_DRAW;
      // travel only counts when X heads the configured way
      if ((len > 0 && !xneg) || (len < 0 && xneg)) begin
        if ((len < 0 && yneg) || (len > 0 && !yneg)) begin
          gest_travel = gest_travel + ym;
          if (gest_travel > TRAVEL_MAX) gest_travel = TRAVEL_MAX;
          if (gest_travel < TRAVEL_MIN) gest_travel = TRAVEL_MIN;
        end
        if (((len > 0 && gest_travel >= len) || (len < 0 && gest_travel <= len)) &&
            gest_phase == PHASE_CODE_DRAW)
          gest_phase = PHASE_CODE_DONE;
      end
    end
    rep.left_btn   = frame_head[B_LEFT];
    rep.middle_btn = frame_head[B_MIDDLE];
    rep.right_btn  = frame_head[B_RIGHT];
    rep.x_ovf      = frame_head[B_XOVF];
    rep.y_ovf      = frame_head[B_YOVF];
    rep.x_move     = {xneg, frame_middle};
    rep.y_move     = {yneg, tail_b};
    rep.phase      = gest_phase;
    rep.travel     = gest_travel[TRAVEL_OUT_W-1:0];
    return 1'b1;
  endfunction

  task automatic pause_input();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (tight_input || r < 55) return;
    n = (r < 92) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    @(negedge clk);
    in_valid = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b);
    mouse_report_t rep;
    @(negedge clk);
    in_valid = 1'b1;
    in_rx_byte = b;
    do @(posedge clk); while (!in_ready);
    if (decode_byte(b, rep)) pending_reports.push_back(rep);
    pause_input();
  endtask

  task automatic write_length(input logic signed [LEN_W-1:0] v);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    gest_length = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // wait for every due report, then idle with no input to let the pipe settle
  task automatic drain_results();
    int n;
    @(negedge clk);
    in_valid = 1'b0;
    for (n = 0; n < WATCHDOG_LIMIT && pending_reports.size() != 0; n++) @(posedge clk);
    if (pending_reports.size() != 0) begin
      $display("%0t: %0d expected reports never arrived", $time, pending_reports.size());
      failures++;
      pending_reports.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic realign();
    while (frame_idx != IDX_HEAD) send_byte(8'h00);
  endtask

  task automatic run_random(input int n_bytes, input int hold_pct);
    logic [7:0] head;
    int         sent;
    int         r;
    sent = 0;
    while (sent < n_bytes) begin
      if (sent % 60 == 0) tight_input = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 8) begin
        send_byte(8'($urandom));
      end else if (r < 14) begin
        // truncated packet, framing has to find its way back
        head = 8'($urandom);
        head[B_SYNC] = 1'b1;
        send_byte(head);
        if ($urandom_range(0, 1) == 1) send_byte(8'($urandom));
      end else begin
        head = 8'($urandom);
        head[B_SYNC] = 1'b1;
        head[B_RIGHT] = ($urandom_range(0, 99) < hold_pct);
        if (gest_length != 0 && $urandom_range(0, 9) < 7) head[B_XSIGN] = (gest_length < 0);
        if (gest_length != 0 && $urandom_range(0, 9) < 7) head[B_YSIGN] = (gest_length < 0);
        send_byte(head);
        send_byte(8'($urandom));
        send_byte(8'($urandom));
        sent += 3;
      end
    end
    tight_input = 1'b0;
  endtask

  task automatic test_framing();
    write_length('0);
    send_byte(8'h00);                                     // no sync bit
    send_byte(8'hF7);
    send_byte(8'h08); send_byte(8'h11); send_byte(8'h22); // first packet, swallowed
    send_byte(8'hFF); send_byte(8'h00); send_byte(8'h00); // every flag, -256 both ways
    send_byte(8'h08); send_byte(8'hFF); send_byte(8'hFF); // +255 both ways, released
    send_byte(8'h0B); send_byte(8'h80); send_byte(8'h7F);
    send_byte(8'h07);                                     // stray byte without sync bit, dropped
    send_byte(8'hCD); send_byte(8'h55); send_byte(8'hAA);
    send_byte(8'h0A); send_byte(8'h00);                   // head and middle; the next byte 8'h3E completes it as tail
    send_byte(8'h3E); send_byte(8'h01); send_byte(8'h02);
    send_byte(8'h2A); send_byte(8'h01); send_byte(8'h80);
    drain_results();
  endtask

  task automatic test_idle_draw();
    write_length('0);
    run_random(RANDOM_BYTES / 5, 70);
    drain_results();
    write_length(LEN_MIN);
    run_random(RANDOM_BYTES / 5, 97);
    drain_results();
  endtask

  // threshold is reached exactly at 10, off-axis moves are ignored
  task automatic test_completion();
    write_length(16'sd10);
    realign();
    send_byte(8'h08); send_byte(8'h00); send_byte(8'h00);
    send_byte(8'h0A); send_byte(8'h10); send_byte(8'h04);
    send_byte(8'h0A); send_byte(8'h00); send_byte(8'h05);
    send_byte(8'h1A); send_byte(8'h00); send_byte(8'h7F);
    send_byte(8'h2A); send_byte(8'h00); send_byte(8'h00);
    send_byte(8'h0A); send_byte(8'h00); send_byte(8'h01);
    send_byte(8'h08); send_byte(8'h00); send_byte(8'h00);
    drain_results();
  endtask

  task automatic test_saturation(input logic signed [LEN_W-1:0] len);
    logic [7:0] head;
    int         extra;
    write_length(len);
    realign();
    tight_input = 1'b1;
    send_byte(8'h08); send_byte(8'h00); send_byte(8'h00);
    extra = 0;
    while (extra < 3) begin
      if (gest_travel >= TRAVEL_MAX || gest_travel <= TRAVEL_MIN) extra++;
      head = 8'($urandom);
      head[B_SYNC] = 1'b1;
      head[B_RIGHT] = 1'b1;
      head[B_XSIGN] = (len < 0);
      head[B_YSIGN] = (len < 0);
      send_byte(head);
      send_byte(8'($urandom));
      send_byte((len < 0) ? 8'h00 : 8'hFF);
    end
    tight_input = 1'b0;
    drain_results();
  endtask

  task automatic test_random_lengths();
    logic signed [LEN_W-1:0] lens[6];
    lens[0] = 16'sd1;
    lens[1] = -16'sd1;
    lens[2] = LEN_W'($urandom_range(2, 400));
    lens[3] = LEN_W'(-int'($urandom_range(2, 400)));
    lens[4] = LEN_MAX;
    lens[5] = '0;
    foreach (lens[i]) begin
      write_length(lens[i]);
      run_random(RANDOM_BYTES / 10, 85);
      drain_results();
    end
  endtask

  task automatic check_field(input string fname, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected report transfer, x_move %0d y_move %0d travel %0d",
                 $time, out_x_move, out_y_move, out_travel_out);
        failures++;
      end else begin
        due_report = pending_reports.pop_front();
        check_field("left_button", due_report.left_btn, out_left_button);
        check_field("middle_button", due_report.middle_btn, out_middle_button);
        check_field("right_button", due_report.right_btn, out_right_button);
        check_field("x_overflow", due_report.x_ovf, out_x_overflow);
        check_field("y_overflow", due_report.y_ovf, out_y_overflow);
        check_field("x_move", $signed(due_report.x_move), out_x_move);
        check_field("y_move", $signed(due_report.y_move), out_y_move);
        check_field("gesture_phase", due_report.phase, out_gesture_phase_out);
        check_field("travel", $signed(due_report.travel), out_travel_out);
      end
    end
  end

  // receiver: mostly ready, short and long stalls, some long stall-free runs
  initial begin : out_ready_pattern
    int r;
    int n;
    forever begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        out_ready = 1'b1;
        n = $urandom_range(1, 24);
      end else if (r < 65) begin
        out_ready = 1'b1;
        n = $urandom_range(40, 120);
      end else if (r < 93) begin
        out_ready = 1'b0;
        n = $urandom_range(1, 3);
      end else begin
        out_ready = 1'b0;
        n = $urandom_range(10, 40);
      end
      repeat (n) @(negedge clk);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    test_framing();
    test_idle_draw();
    test_completion();
    test_random_lengths();
    test_saturation(LEN_MIN);
    drain_results();
    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
